>>> rtl/core/ecs_pkg.sv
// shared constants, codes and command/status types of the epipolar search
// no dependencies
package ecs_pkg;

    localparam int COORD_W      = 11;
    localparam int IDX_W        = 11;
    localparam int CNT_W        = 12;
    localparam int MAX_POINTS   = 2048;
    localparam int F_W          = 48;
    localparam int COEF_W       = 64;
    localparam int WIDE_W       = 80;
    localparam int NUM_REGS     = 8;
    localparam int CFG_IDX_W    = 4;
    localparam int STEP_W       = 3;
    localparam int EDGE_W       = 11;
    localparam int RIGHT_EDGE_X = 719;
    localparam int FRAC_BITS    = 44;
    localparam int LINE_STEPS   = 6;

    localparam logic [COEF_W-1:0] ONE_FIX = COEF_W'(1) << FRAC_BITS;

    typedef enum logic [1:0] {
        OP_CLEAR  = 2'd0,
        OP_APPEND = 2'd1,
        OP_QUERY  = 2'd2,
        OP_NONE   = 2'd3
    } t_op;

    typedef struct packed {
        logic clear;
        logic append;
        logic load_query;
        logic line_step;
        logic edge_mul;
        logic mul;
        logic eval;
        logic finish;
    } t_cmd;

    typedef struct packed {
        logic line_last;
        logic b_zero;
        logic count_zero;
        logic scan_last;
        logic out_busy;
    } t_status;

endpackage

>>> rtl/core/ecs_ctrl.sv
// controller state machine of the epipolar search
// depends on ecs_pkg
module ecs_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  logic [1:0]        i_operation,
    input  ecs_pkg::t_status  i_status,
    output ecs_pkg::t_cmd     o_cmd
);

    typedef enum logic [6:0] {
        S_IDLE = 7'b0000001,
        S_LINE = 7'b0000010,
        S_EDGE = 7'b0000100,
        S_RD   = 7'b0001000,
        S_MUL  = 7'b0010000,
        S_EVAL = 7'b0100000,
        S_DONE = 7'b1000000
    } t_state;

    t_state r_state, n_state;
    logic   w_accept;

    assign o_ready  = (r_state == S_IDLE);
    assign w_accept = i_valid && o_ready;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    case (i_operation)
                        ecs_pkg::OP_CLEAR:  o_cmd.clear = 1'b1;
                        ecs_pkg::OP_APPEND: o_cmd.append = 1'b1;
                        ecs_pkg::OP_QUERY: begin
                            o_cmd.load_query = 1'b1;
                            n_state = S_LINE;
                        end
                        default: ;
                    endcase
                end
            end
            S_LINE: begin
                o_cmd.line_step = 1'b1;
                if (i_status.line_last) n_state = S_EDGE;
            end
            S_EDGE: begin
                o_cmd.edge_mul = 1'b1;
                if (i_status.b_zero || i_status.count_zero) n_state = S_DONE;
                else n_state = S_RD;
            end
            S_RD: n_state = S_MUL;
            S_MUL: begin
                o_cmd.mul = 1'b1;
                n_state = S_EVAL;
            end
            S_EVAL: begin
                o_cmd.eval = 1'b1;
                if (i_status.scan_last) n_state = S_DONE;
                else n_state = S_RD;
            end
            S_DONE: begin
                if (!i_status.out_busy) begin
                    o_cmd.finish = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= S_IDLE;
        else          r_state <= n_state;
    end

endmodule

>>> rtl/core/ecs_datapath.sv
// point table, line coefficients, band test and minimum search
// depends on ecs_pkg
module ecs_datapath (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  ecs_pkg::t_cmd                  i_cmd,
    output ecs_pkg::t_status               o_status,
    input  logic [ecs_pkg::COORD_W-1:0]    i_point_x,
    input  logic [ecs_pkg::COORD_W-1:0]    i_point_y,
    input  logic                           i_cfg_valid,
    input  logic [ecs_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [ecs_pkg::F_W-1:0]        i_cfg_data,
    output logic                           o_valid,
    input  logic                           i_ready,
    output logic                           o_found,
    output logic [ecs_pkg::COORD_W-1:0]    o_match_x,
    output logic [ecs_pkg::COORD_W-1:0]    o_match_y,
    output logic [ecs_pkg::IDX_W-1:0]      o_match_index
);

    localparam int MEM_W = 2 * ecs_pkg::COORD_W + 1;
    localparam int CW    = ecs_pkg::COORD_W;

    logic [ecs_pkg::F_W-1:0]    r_f [ecs_pkg::NUM_REGS];
    logic [MEM_W-1:0]           r_mem [ecs_pkg::MAX_POINTS];
    logic [MEM_W-1:0]           r_rdata;
    logic [ecs_pkg::CNT_W-1:0]  r_count;
    logic [ecs_pkg::CNT_W-1:0]  r_idx;
    logic [ecs_pkg::STEP_W-1:0] r_k;
    logic [CW-1:0]              r_qx, r_qy;
    logic signed [ecs_pkg::COEF_W-1:0] r_a, r_b, r_c;
    logic signed [ecs_pkg::WIDE_W-1:0] r_edge, r_by, r_ax;
    logic                       r_used;
    logic [CW-1:0]              r_px, r_py;
    logic                       r_have;
    logic [ecs_pkg::WIDE_W-1:0] r_best;
    logic [ecs_pkg::IDX_W-1:0]  r_best_i;
    logic [CW-1:0]              r_best_x, r_best_y;
    logic                       r_out_valid;

    // line step: row k[2:1], column k[0]
    logic [1:0]                      w_row;
    logic [ecs_pkg::STEP_W-1:0]      w_fsel;
    logic signed [ecs_pkg::F_W-1:0]  w_f;
    logic signed [CW:0]              w_coord;
    logic signed [ecs_pkg::F_W+CW:0] w_prod;
    logic signed [ecs_pkg::COEF_W-1:0] w_prod_ext;

    assign w_row      = r_k[2:1];
    assign w_fsel     = {r_k[2:1], 1'b0} + {1'b0, r_k[2:1]} + {2'b0, r_k[0]};
    assign w_f        = $signed(r_f[w_fsel]);
    assign w_coord    = $signed({1'b0, (r_k[0] ? r_qy : r_qx)});
    assign w_prod     = w_f * w_coord;
    assign w_prod_ext = ecs_pkg::COEF_W'(w_prod);

    logic signed [ecs_pkg::COEF_W+ecs_pkg::EDGE_W-1:0] w_edge_p;
    logic signed [ecs_pkg::COEF_W+CW:0]                w_by_p, w_ax_p;
    logic signed [ecs_pkg::EDGE_W-1:0]                 w_edge_k;

    assign w_edge_k = ecs_pkg::EDGE_W'(ecs_pkg::RIGHT_EDGE_X);
    assign w_edge_p = r_a * w_edge_k;
    assign w_by_p   = r_b * $signed({1'b0, r_rdata[CW-1:0]});
    assign w_ax_p   = r_a * $signed({1'b0, r_rdata[2*CW-1:CW]});

    logic signed [ecs_pkg::WIDE_W-1:0] w_g0, w_g1, w_sum;
    logic [ecs_pkg::WIDE_W-1:0]        w_score;
    logic                              w_inband, w_take;

    assign w_g0     = r_by + ecs_pkg::WIDE_W'(r_c);
    assign w_g1     = w_g0 + r_edge;
    assign w_inband = (w_g0 == '0) || (w_g1 == '0)
                    || (w_g0[ecs_pkg::WIDE_W-1] != w_g1[ecs_pkg::WIDE_W-1]);
    assign w_sum    = r_ax + w_g0;
    assign w_score  = w_sum[ecs_pkg::WIDE_W-1] ? ecs_pkg::WIDE_W'(-w_sum)
                                               : ecs_pkg::WIDE_W'(w_sum);
    assign w_take   = !r_used && w_inband && (!r_have || (w_score < r_best));

    assign o_status.line_last  = (r_k == ecs_pkg::STEP_W'(ecs_pkg::LINE_STEPS - 1));
    assign o_status.b_zero     = (r_b == '0);
    assign o_status.count_zero = (r_count == '0);
    assign o_status.scan_last  = (r_idx == r_count - ecs_pkg::CNT_W'(1));
    assign o_status.out_busy   = r_out_valid && !i_ready;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int j = 0; j < ecs_pkg::NUM_REGS; j++) r_f[j] <= '0;
        end else if (i_cfg_valid && (i_cfg_index < ecs_pkg::CFG_IDX_W'(ecs_pkg::NUM_REGS))) begin
            r_f[i_cfg_index[ecs_pkg::STEP_W-1:0]] <= i_cfg_data;
        end
    end

    // table memory: {used, x, y}; an append writes a fresh used flag, so a clear
    // only resets the fill count
    always_ff @(posedge i_clk) begin
        if (i_cmd.append && (r_count < ecs_pkg::CNT_W'(ecs_pkg::MAX_POINTS)))
            r_mem[r_count[ecs_pkg::IDX_W-1:0]] <= {1'b0, i_point_x, i_point_y};
        else if (i_cmd.finish && r_have)
            r_mem[r_best_i] <= {1'b1, r_best_x, r_best_y};
        r_rdata <= r_mem[r_idx[ecs_pkg::IDX_W-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_cmd.clear) begin
            r_count <= '0;
        end else if (i_cmd.append && (r_count < ecs_pkg::CNT_W'(ecs_pkg::MAX_POINTS))) begin
            r_count <= r_count + ecs_pkg::CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_have <= 1'b0;
            r_k    <= '0;
            r_idx  <= '0;
        end else begin
            if (i_cmd.load_query) begin
                r_have <= 1'b0;
                r_k    <= '0;
            end
            if (i_cmd.line_step) r_k <= r_k + ecs_pkg::STEP_W'(1);
            if (i_cmd.edge_mul)  r_idx <= '0;
            if (i_cmd.eval) begin
                r_idx <= r_idx + ecs_pkg::CNT_W'(1);
                if (w_take) r_have <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_query) begin
            r_qx <= i_point_x;
            r_qy <= i_point_y;
            r_a  <= ecs_pkg::COEF_W'($signed(r_f[2]));
            r_b  <= ecs_pkg::COEF_W'($signed(r_f[5]));
            r_c  <= ecs_pkg::ONE_FIX;
        end
        if (i_cmd.line_step) begin
            case (w_row)
                2'd0:    r_a <= r_a + w_prod_ext;
                2'd1:    r_b <= r_b + w_prod_ext;
                default: r_c <= r_c + w_prod_ext;
            endcase
        end
        if (i_cmd.edge_mul) r_edge <= ecs_pkg::WIDE_W'(w_edge_p);
        if (i_cmd.mul) begin
            r_by   <= ecs_pkg::WIDE_W'(w_by_p);
            r_ax   <= ecs_pkg::WIDE_W'(w_ax_p);
            r_used <= r_rdata[MEM_W-1];
            r_px   <= r_rdata[2*CW-1:CW];
            r_py   <= r_rdata[CW-1:0];
        end
        if (i_cmd.eval && w_take) begin
            r_best   <= w_score;
            r_best_i <= r_idx[ecs_pkg::IDX_W-1:0];
            r_best_x <= r_px;
            r_best_y <= r_py;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.finish) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.finish) begin
            o_found       <= r_have;
            o_match_x     <= r_have ? r_best_x : '0;
            o_match_y     <= r_have ? r_best_y : '0;
            o_match_index <= r_have ? r_best_i : '0;
        end
    end

    assign o_valid = r_out_valid;

endmodule

>>> rtl/core/epipolar_correspondence_search.sv
// top level of the epipolar correspondence search
// depends on ecs_pkg, ecs_ctrl and ecs_datapath
//
// input channel (i_valid/o_ready) carries one operation beat: clear, append
// or query; operation code 3 is dropped. clear and append give no result.
// a query gives exactly one result beat on o_valid/i_ready.
// config channel (i_cfg_valid/o_cfg_ready) writes the eight matrix entries,
// index 0..7; other indexes are dropped. o_cfg_ready is always high.
// a query runs the line steps, then the band edge product, then for each
// stored point a memory read, the products, and the band test and compare,
// then loads the result; the per-point loop over the single table read port
// sets the query time, and it is skipped for an empty table or a zero b.
// the result sits in an output register, so after it is loaded a new beat is
// accepted even while the receiver stalls; a later query waits at its end
// until that register is free.
// synchronous reset clears the fill count and matrix registers.
module epipolar_correspondence_search (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    output logic                           o_ready,
    input  logic [1:0]                     i_operation,
    input  logic [ecs_pkg::COORD_W-1:0]    i_point_x,
    input  logic [ecs_pkg::COORD_W-1:0]    i_point_y,
    output logic                           o_valid,
    input  logic                           i_ready,
    output logic                           o_found,
    output logic [ecs_pkg::COORD_W-1:0]    o_match_x,
    output logic [ecs_pkg::COORD_W-1:0]    o_match_y,
    output logic [ecs_pkg::IDX_W-1:0]      o_match_index,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [ecs_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [ecs_pkg::F_W-1:0]        i_cfg_data
);

    ecs_pkg::t_cmd    w_cmd;
    ecs_pkg::t_status w_status;

    assign o_cfg_ready = 1'b1;

    ecs_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_operation (i_operation),
        .i_status    (w_status),
        .o_cmd       (w_cmd)
    );

    ecs_datapath u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (w_cmd),
        .o_status      (w_status),
        .i_point_x     (i_point_x),
        .i_point_y     (i_point_y),
        .i_cfg_valid   (i_cfg_valid),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_found       (o_found),
        .o_match_x     (o_match_x),
        .o_match_y     (o_match_y),
        .o_match_index (o_match_index)
    );

endmodule
